// ----- src/plt_pkg.sv -----
package plt_pkg;

	// default table depth
	localparam int TABLE_DEPTH_DEF = 64;

	// field widths
	localparam int BP_W        = 31;
	localparam int VAL_W       = 32;
	localparam int Q_W         = 32;
	localparam int ENTRY_IDX_W = 6;
	localparam int SEG_OUT_W   = 6;
	localparam int ENTRIES_W   = 7;
	localparam int CFG_DATA_W  = 7;
	localparam int CFG_IDX_W   = 1;

	// product and divisor magnitude widths
	localparam int PROD_W = 64;
	localparam int DEN_W  = 31;

	typedef enum logic {
		CMD_WRITE = 1'b0,
		CMD_QUERY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		RC_BELOW  = 2'd0,
		RC_INTERP = 2'd1,
		RC_ABOVE  = 2'd2,
		RC_FLOOR  = 2'd3
	} range_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ENTRIES = 1'b0,
		CFG_FLOOR   = 1'b1
	} cfg_idx_t;

endpackage

// ----- src/plt_ram.sv -----
module plt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// ----- src/plt_div.sv -----
module plt_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [plt_pkg::PROD_W-1:0] dividend,
	input  logic [plt_pkg::DEN_W-1:0]  divisor,
	output logic                       done,
	output logic [plt_pkg::PROD_W-1:0] quotient
);

	import plt_pkg::*;

	localparam int CNT_W = $clog2(PROD_W + 1);

	logic             active_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] dvs_q;
	logic [PROD_W-1:0] quo_q;

	logic [DEN_W:0] rem_sh;
	logic [DEN_W:0] rem_sub;
	logic           ge;

	// one restoring step: shift in the next dividend bit, try subtract
	assign rem_sh  = {rem_q, quo_q[PROD_W-1]};
	assign rem_sub = rem_sh - {1'b0, dvs_q};
	assign ge      = rem_sh >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			cnt_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				cnt_q    <= CNT_W'(PROD_W);
			end else if (active_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (active_q) begin
			quo_q <= {quo_q[PROD_W-2:0], ge};
			rem_q <= ge ? rem_sub[DEN_W-1:0] : rem_sh[DEN_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

// ----- src/piecewise_linear_table_lookup.sv -----
// Piecewise linear table lookup. A command with cmd = write stores one table entry
// (breakpoint and Q16.16 value) and gives no result. A query is answered by one
// result strobe: a query outside the range (zero or negative per floor_mode)
// answers in the cycle after start, a query at or past the last breakpoint from
// state S_LAST once the last entry has been read. An interpolated query walks the
// table one entry per cycle from entry 1 to the segment it falls in, then runs one
// 33x33 multiply and a bit-serial 64-bit divide (one quotient bit a cycle); a
// segment of zero width skips the divide. busy is high while a query is in flight
// and start is ignored then. result_valid is high for exactly one cycle per query
// and the receiver cannot stall it; results must be taken when shown.
// Configuration writes are always accepted (cfg_ready is tied high) and are meant
// to be issued only while busy is low.
module piecewise_linear_table_lookup #(
	parameter int TABLE_DEPTH = plt_pkg::TABLE_DEPTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// command channel
	input  logic                            start,
	output logic                            busy,
	input  logic                            cmd,
	input  logic [plt_pkg::ENTRY_IDX_W-1:0] entry_index,
	input  logic [plt_pkg::BP_W-1:0]        breakpoint,
	input  logic signed [plt_pkg::VAL_W-1:0] entry_value,
	input  logic signed [plt_pkg::Q_W-1:0]  query_point,
	// configuration channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [plt_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [plt_pkg::CFG_DATA_W-1:0]  cfg_data,
	// result channel
	output logic                            result_valid,
	output logic signed [plt_pkg::VAL_W-1:0] result_value,
	output logic [1:0]                      range_code,
	output logic [plt_pkg::SEG_OUT_W-1:0]   segment_index
);

	import plt_pkg::*;

	localparam int IDX_W  = $clog2(TABLE_DEPTH);
	localparam int CNT_W  = ($clog2(TABLE_DEPTH + 1) > ENTRIES_W) ?
		$clog2(TABLE_DEPTH + 1) : ENTRIES_W;
	localparam int EXT_W  = (IDX_W > SEG_OUT_W) ? IDX_W : SEG_OUT_W;
	localparam int WORD_W = BP_W + VAL_W;
	localparam int MUL_W  = 2 * (VAL_W + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_LAST,
		S_SRCH,
		S_LO,
		S_MUL,
		S_DIVGO,
		S_DIVW,
		S_FIN
	} state_t;

	state_t state_q;

	// configuration registers
	logic [ENTRIES_W-1:0] entries_q;
	logic                 floor_q;

	// query datapath registers
	logic [IDX_W-1:0]          seg_q;
	logic [Q_W-1:0]            q_q;
	logic [BP_W-1:0]           x1_q;
	logic signed [VAL_W-1:0]   v1_q;
	logic signed [VAL_W-1:0]   v0_q;
	logic signed [VAL_W:0]     dv_q;
	logic signed [Q_W:0]       dq_q;
	logic signed [BP_W:0]      den_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic                      neg_q;
	logic signed [PROD_W-1:0]  sq_q;

	// result registers
	logic                     res_valid_q;
	logic signed [VAL_W-1:0]  res_value_q;
	range_t                   res_code_q;
	logic [SEG_OUT_W-1:0]     res_seg_q;

	// table memory
	logic               ram_we;
	logic [IDX_W-1:0]   ram_addr;
	logic [WORD_W-1:0]  ram_rdata;
	logic [BP_W-1:0]    rd_bp;
	logic signed [VAL_W-1:0] rd_val;

	// misc comb
	logic [CNT_W-1:0]   ent_ext;
	logic [CNT_W-1:0]   n_sat;
	logic [CNT_W-1:0]   last_full;
	logic [IDX_W-1:0]   last_idx;
	logic [EXT_W-1:0]   last_ext;
	logic [EXT_W-1:0]   seg_ext;
	logic [EXT_W-1:0]   wr_ext;
	logic [IDX_W-1:0]   wr_addr;
	logic               wr_ok;
	logic               below;
	logic               go_on;
	logic signed [MUL_W-1:0]  mult;
	logic [PROD_W-1:0]  prod_mag;
	logic [BP_W:0]      den_neg;
	logic [DEN_W-1:0]   den_mag;
	logic               div_start;
	logic               div_done;
	logic [PROD_W-1:0]  div_quo;
	logic signed [PROD_W:0] sum_w;
	logic               ovf_hi;
	logic               ovf_lo;
	logic signed [VAL_W-1:0] sat_val;

	assign rd_bp  = ram_rdata[WORD_W-1:VAL_W];
	assign rd_val = ram_rdata[VAL_W-1:0];

	// entry count saturated into [2, depth]
	always_comb begin
		ent_ext = CNT_W'(entries_q);
		if (ent_ext > CNT_W'(TABLE_DEPTH)) begin
			n_sat = CNT_W'(TABLE_DEPTH);
		end else if (ent_ext < CNT_W'(2)) begin
			n_sat = CNT_W'(2);
		end else begin
			n_sat = ent_ext;
		end
	end

	assign last_full = n_sat - CNT_W'(1);
	assign last_idx  = last_full[IDX_W-1:0];
	assign last_ext  = EXT_W'(last_idx);
	assign seg_ext   = EXT_W'(seg_q);

	// write address, writes beyond the table are dropped
	assign wr_ext  = EXT_W'(entry_index);
	assign wr_addr = wr_ext[IDX_W-1:0];
	assign wr_ok   = CNT_W'(entry_index) < CNT_W'(TABLE_DEPTH);

	// query outside the range
	assign below = floor_q ? (query_point[Q_W-1] || (query_point == '0))
		: query_point[Q_W-1];

	// search continues while the entry read is not above the query, up to the last entry
	assign go_on = (seg_q != last_idx) && ({1'b0, rd_bp} <= q_q);

	// memory address and write enable
	always_comb begin
		ram_we   = 1'b0;
		ram_addr = last_idx;
		case (state_q)
			S_IDLE: begin
				if (start && (cmd == CMD_WRITE)) begin
					ram_addr = wr_addr;
					ram_we   = wr_ok;
				end
			end
			S_LAST: begin
				ram_addr = IDX_W'(1);
			end
			S_SRCH: begin
				ram_addr = go_on ? (seg_q + IDX_W'(1)) : (seg_q - IDX_W'(1));
			end
			default: begin
				ram_addr = last_idx;
			end
		endcase
	end

	plt_ram #(
		.WIDTH(WORD_W),
		.DEPTH(TABLE_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata({breakpoint, entry_value}),
		.rdata(ram_rdata)
	);

	// slope times offset
	assign mult = dv_q * dq_q;

	// magnitudes for the divider
	assign prod_mag  = prod_q[PROD_W-1] ? (~prod_q + PROD_W'(1)) : prod_q;
	assign den_neg   = ~den_q + (BP_W+1)'(1);
	assign den_mag   = den_q[BP_W] ? den_neg[DEN_W-1:0] : den_q[DEN_W-1:0];
	assign div_start = (state_q == S_DIVGO) && (den_q != '0);

	plt_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (div_start),
		.dividend(prod_mag),
		.divisor (den_mag),
		.done    (div_done),
		.quotient(div_quo)
	);

	// final add and saturation to 32 bits
	assign sum_w  = {{(PROD_W-VAL_W+1){v0_q[VAL_W-1]}}, v0_q} + {sq_q[PROD_W-1], sq_q};
	assign ovf_hi = !sum_w[PROD_W] && (|sum_w[PROD_W-1:VAL_W-1]);
	assign ovf_lo = sum_w[PROD_W] && !(&sum_w[PROD_W-1:VAL_W-1]);

	always_comb begin
		if (ovf_hi) begin
			sat_val = {1'b0, {(VAL_W-1){1'b1}}};
		end else if (ovf_lo) begin
			sat_val = {1'b1, {(VAL_W-1){1'b0}}};
		end else begin
			sat_val = sum_w[VAL_W-1:0];
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_W'(2);
			floor_q   <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_ENTRIES) begin
				entries_q <= cfg_data[ENTRIES_W-1:0];
			end else if (cfg_index == CFG_FLOOR) begin
				floor_q <= cfg_data[0];
			end
		end
	end

	// sequencer and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			res_value_q <= '0;
			res_code_q  <= RC_BELOW;
			res_seg_q   <= '0;
		end else begin
			res_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (start && (cmd == CMD_QUERY)) begin
						if (below) begin
							res_valid_q <= 1'b1;
							res_value_q <= '0;
							res_code_q  <= RC_BELOW;
							res_seg_q   <= '0;
						end else begin
							state_q <= S_LAST;
						end
					end
				end
				S_LAST: begin
					if (q_q >= {1'b0, rd_bp}) begin
						res_valid_q <= 1'b1;
						res_value_q <= rd_val;
						res_code_q  <= RC_ABOVE;
						res_seg_q   <= last_ext[SEG_OUT_W-1:0];
						state_q     <= S_IDLE;
					end else begin
						state_q <= S_SRCH;
					end
				end
				S_SRCH: begin
					if (!go_on) begin
						state_q <= S_LO;
					end
				end
				S_LO: begin
					state_q <= S_MUL;
				end
				S_MUL: begin
					state_q <= S_DIVGO;
				end
				S_DIVGO: begin
					state_q <= (den_q == '0) ? S_FIN : S_DIVW;
				end
				S_DIVW: begin
					if (div_done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					res_valid_q <= 1'b1;
					res_seg_q   <= seg_ext[SEG_OUT_W-1:0];
					if (floor_q && sat_val[VAL_W-1]) begin
						res_value_q <= '0;
						res_code_q  <= RC_FLOOR;
					end else begin
						res_value_q <= sat_val;
						res_code_q  <= RC_INTERP;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// query datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				q_q <= query_point;
			end
			S_LAST: begin
				seg_q <= IDX_W'(1);
			end
			S_SRCH: begin
				if (go_on) begin
					seg_q <= seg_q + IDX_W'(1);
				end else begin
					x1_q <= rd_bp;
					v1_q <= rd_val;
				end
			end
			S_LO: begin
				v0_q  <= rd_val;
				dv_q  <= {v1_q[VAL_W-1], v1_q} - {rd_val[VAL_W-1], rd_val};
				dq_q  <= {1'b0, q_q} - {2'b00, rd_bp};
				den_q <= {1'b0, x1_q} - {1'b0, rd_bp};
			end
			S_MUL: begin
				prod_q <= mult[PROD_W-1:0];
			end
			S_DIVGO: begin
				neg_q <= prod_q[PROD_W-1] ^ den_q[BP_W];
				if (den_q == '0) begin
					sq_q <= '0;
				end
			end
			S_DIVW: begin
				if (div_done) begin
					sq_q <= neg_q ? (~div_quo + PROD_W'(1)) : div_quo;
				end
			end
			default: begin
			end
		endcase
	end

	assign busy          = (state_q != S_IDLE);
	assign cfg_ready     = 1'b1;
	assign result_valid  = res_valid_q;
	assign result_value  = res_value_q;
	assign range_code    = res_code_q;
	assign segment_index = res_seg_q;

endmodule

// ----- tb/piecewise_linear_table_lookup_tb.sv -----
`timescale 1ns / 100ps

module piecewise_linear_table_lookup_tb;

	import plt_pkg::*;

	localparam int DEPTH             = 64;
	localparam int CYCLE_LIMIT       = 1000000;
	localparam int QUERIES_PER_PHASE = 16;
	localparam int SETTLE_CYCLES     = 4;
	localparam int TAIL_CYCLES       = 150;
	localparam int NUM_PHASES        = 8;
	localparam int NUM_ROWS          = 25;

	typedef struct packed {
		logic signed [VAL_W-1:0]     value;
		range_t                      code;
		logic [SEG_OUT_W-1:0]        seg;
	} lookup_answer_t;

	typedef enum logic {
		ROW_CMD = 1'b0,
		ROW_CFG = 1'b1
	} row_kind_t;

	// one line of the directed table; typed rows carry their answer
	typedef struct packed {
		row_kind_t                   kind;
		cmd_t                        op;
		logic [ENTRY_IDX_W-1:0]      idx;
		logic [BP_W-1:0]             bp;
		logic signed [VAL_W-1:0]     val;
		logic signed [Q_W-1:0]       qp;
		cfg_idx_t                    reg_idx;
		logic [CFG_DATA_W-1:0]       reg_data;
		logic                        typed;
		logic signed [VAL_W-1:0]     e_val;
		range_t                      e_code;
		logic [SEG_OUT_W-1:0]        e_seg;
	} dir_row_t;

	logic                            clk;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic                            cmd;
	logic [ENTRY_IDX_W-1:0]          entry_index;
	logic [BP_W-1:0]                 breakpoint;
	logic signed [VAL_W-1:0]         entry_value;
	logic signed [Q_W-1:0]           query_point;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [CFG_IDX_W-1:0]            cfg_index;
	logic [CFG_DATA_W-1:0]           cfg_data;
	logic                            result_valid;
	logic signed [VAL_W-1:0]         result_value;
	logic [1:0]                      range_code;
	logic [SEG_OUT_W-1:0]            segment_index;

	// shadow of the table and registers
	logic [BP_W-1:0]                 bp_shadow [DEPTH];
	logic signed [VAL_W-1:0]         val_shadow [DEPTH];
	logic [ENTRIES_W-1:0]            shadow_entries;
	logic                            shadow_floor;

	lookup_answer_t                  pending_answers [$];
	lookup_answer_t                  no_answer;
	logic                            typed_now;
	lookup_answer_t                  typed_answer;

	int                              idle_pct;
	int                              errors;
	int                              cycles;
	int                              n_writes;
	int                              n_queries;
	int                              n_checked;
	int                              n_reg_writes;
	int                              code_seen [4];

	piecewise_linear_table_lookup DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.cmd          (cmd),
		.entry_index  (entry_index),
		.breakpoint   (breakpoint),
		.entry_value  (entry_value),
		.query_point  (query_point),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.result_valid (result_valid),
		.result_value (result_value),
		.range_code   (range_code),
		.segment_index(segment_index)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// entry count as the block uses it
	function automatic int eff_entries(input logic [ENTRIES_W-1:0] raw);
		int n;
		n = raw;
		if (n > DEPTH)
			n = DEPTH;
		if (n < 2)
			n = 2;
		return n;
	endfunction

	// expected answer of a query against the shadow table
	function automatic lookup_answer_t interpolate_lookup(input logic signed [Q_W-1:0] qp);
		lookup_answer_t a;
		int last;
		int s;
		longint q, x0, x1, v0, v1, den, r;
		last = eff_entries(shadow_entries) - 1;
		q = qp;
		if (shadow_floor ? (q <= 0) : (q < 0)) begin
			a.value = '0;
			a.code  = RC_BELOW;
			a.seg   = '0;
			return a;
		end
		if (q >= longint'(bp_shadow[last])) begin
			a.value = val_shadow[last];
			a.code  = RC_ABOVE;
			a.seg   = SEG_OUT_W'(last);
			return a;
		end
		s = 1;
		while (s < last && longint'(bp_shadow[s]) <= q)
			s++;
		x0 = bp_shadow[s-1];
		x1 = bp_shadow[s];
		v0 = val_shadow[s-1];
		v1 = val_shadow[s];
		den = x1 - x0;
		if (den == 0)
			r = v0;
		else
			r = v0 + ((v1 - v0) * (q - x0)) / den;
		// saturate to 32 bits before the floor
		if (r > 64'sd2147483647)
			r = 64'sd2147483647;
		if (r < -64'sd2147483648)
			r = -64'sd2147483648;
		a.seg = SEG_OUT_W'(s);
		if (shadow_floor && r < 0) begin
			a.value = '0;
			a.code  = RC_FLOOR;
		end else begin
			a.value = VAL_W'(r);
			a.code  = RC_INTERP;
		end
		return a;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
		errors++;
	endtask

	// monitor: check answers, track accepted beats, watchdog
	always @(posedge clk) begin
		lookup_answer_t want;
		if (arst_n) begin
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("Timeout after %0d cycles", cycles);
				$display("Some tests failed");
				$finish;
			end
			if (result_valid) begin
				if (pending_answers.size() == 0) begin
					report_mismatch("unexpected result_value", result_value, 0);
				end else begin
					want = pending_answers.pop_front();
					n_checked++;
					code_seen[range_code]++;
					if (result_value !== want.value)
						report_mismatch("result_value", result_value, want.value);
					if (range_code !== want.code)
						report_mismatch("range_code", range_code, want.code);
					if (segment_index !== want.seg)
						report_mismatch("segment_index", segment_index, want.seg);
				end
			end
			if (start && !busy) begin
				if (cmd == CMD_WRITE) begin
					bp_shadow[entry_index]  = breakpoint;
					val_shadow[entry_index] = entry_value;
					n_writes++;
				end else begin
					n_queries++;
					if (typed_now)
						pending_answers.insert(pending_answers.size(), typed_answer);
					else
						pending_answers.insert(pending_answers.size(),
							interpolate_lookup(query_point));
				end
			end
			if (cfg_valid && cfg_ready) begin
				n_reg_writes++;
				if (cfg_index == CFG_ENTRIES)
					shadow_entries = cfg_data[ENTRIES_W-1:0];
				else
					shadow_floor = cfg_data[0];
			end
		end
	end

	// one command beat, with an optional idle gap before it
	task automatic issue(input cmd_t op, input logic [ENTRY_IDX_W-1:0] idx,
			input logic [BP_W-1:0] bp, input logic signed [VAL_W-1:0] val,
			input logic signed [Q_W-1:0] qp, input logic typed, input lookup_answer_t ta);
		int gap;
		@(negedge clk);
		if ($urandom_range(0, 99) < idle_pct) begin
			start <= 1'b0;
			gap = $urandom_range(1, 5);
			repeat (gap) @(negedge clk);
		end
		start        <= 1'b1;
		cmd          <= op;
		entry_index  <= idx;
		breakpoint   <= bp;
		entry_value  <= val;
		query_point  <= qp;
		typed_now    = typed;
		typed_answer = ta;
		do @(posedge clk); while (busy);
	endtask

	// let the block go idle with nothing outstanding
	task automatic drain();
		@(negedge clk);
		start <= 1'b0;
		while (pending_answers.size() != 0 || busy)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_reg(input cfg_idx_t ri, input logic [CFG_DATA_W-1:0] data);
		drain();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// rewrite entries 0..n-1, mostly ascending at a random scale
	task automatic load_table(input int n);
		int kind;
		int unsigned base, step_max, bpv;
		logic signed [VAL_W-1:0] v;
		kind = $urandom_range(0, 9);
		base = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5000);
		case (kind)
			0, 1, 2: step_max = 64;
			3, 4:    step_max = 1 << 20;
			default: step_max = (32'h7FFF_FFFF - base) / n;
		endcase
		bpv = base;
		for (int i = 0; i < n; i++) begin
			if (kind >= 8)
				bpv = $urandom & 32'h7FFF_FFFF;
			else if (i > 0 && !(kind == 7 && $urandom_range(0, 3) == 0))
				bpv = bpv + $urandom_range(1, step_max);
			if ($urandom_range(0, 1))
				v = $urandom;
			else
				v = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
			issue(CMD_WRITE, ENTRY_IDX_W'(i), BP_W'(bpv), v, $urandom, 1'b0, no_answer);
		end
	endtask

	// one random query, sometimes replaced by a stray table write
	task automatic random_query(input int last);
		int pick, k;
		int unsigned lo, hi;
		logic signed [Q_W-1:0] qp;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			issue(CMD_WRITE, ENTRY_IDX_W'($urandom), BP_W'($urandom), $urandom, $urandom,
				1'b0, no_answer);
			return;
		end
		if (pick < 60) begin
			k  = $urandom_range(1, last);
			lo = bp_shadow[k-1];
			hi = bp_shadow[k];
			qp = (hi > lo) ? $urandom_range(lo, hi - 1) : lo;
		end else if (pick < 70) begin
			qp = bp_shadow[$urandom_range(0, last)];
		end else if (pick < 78) begin
			lo = bp_shadow[last];
			qp = lo + $urandom_range(0, 32'h7FFF_FFFF - lo);
		end else if (pick < 84) begin
			qp = $urandom_range(0, bp_shadow[0]);
		end else if (pick < 90) begin
			qp = ($urandom_range(0, 2) == 0) ? 0 : ($urandom | 32'h8000_0000);
		end else begin
			qp = $urandom;
		end
		issue(CMD_QUERY, ENTRY_IDX_W'($urandom), BP_W'($urandom), $urandom, qp,
			1'b0, no_answer);
	endtask

	// directed rows; table starts as breakpoint 1000*i, value i.0
	dir_row_t dir_rows [NUM_ROWS] = '{
		// floor mode, two entries: zero and most negative query, above range
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd0, CFG_ENTRIES, 0, 1, 0, RC_BELOW, 0},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'h8000_0000, CFG_ENTRIES, 0, 1, 0, RC_BELOW, 0},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd1000, CFG_ENTRIES, 0, 1, 32'h0001_0000, RC_ABOVE, 1},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'h7FFF_FFFF, CFG_ENTRIES, 0, 1, 32'h0001_0000,
			RC_ABOVE, 1},
		// plain mode: zero query interpolates, negative does not
		'{ROW_CFG, CMD_QUERY, 0, 0, 0, 0, CFG_FLOOR, 7'd0, 0, 0, RC_BELOW, 0},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd0, CFG_ENTRIES, 0, 1, 0, RC_INTERP, 1},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'hFFFF_FFFF, CFG_ENTRIES, 0, 1, 0, RC_BELOW, 0},
		// extrapolation below the first breakpoint
		'{ROW_CMD, CMD_WRITE, 0, 31'd500, 32'hFFFB_0000, 0, CFG_ENTRIES, 0, 0, 0, RC_BELOW, 0},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd100, CFG_ENTRIES, 0, 0, 0, RC_BELOW, 0},
		'{ROW_CFG, CMD_QUERY, 0, 0, 0, 0, CFG_FLOOR, 7'd1, 0, 0, RC_BELOW, 0},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd100, CFG_ENTRIES, 0, 0, 0, RC_BELOW, 0},
		// zero segment width
		'{ROW_CMD, CMD_WRITE, 1, 31'd500, 32'h0007_0000, 0, CFG_ENTRIES, 0, 0, 0, RC_BELOW, 0},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd100, CFG_ENTRIES, 0, 0, 0, RC_BELOW, 0},
		'{ROW_CFG, CMD_QUERY, 0, 0, 0, 0, CFG_FLOOR, 7'd0, 0, 0, RC_BELOW, 0},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd100, CFG_ENTRIES, 0, 1, 32'hFFFB_0000, RC_INTERP, 1},
		// saturation high, then low, at the value extremes
		'{ROW_CMD, CMD_WRITE, 0, 31'd2147483000, 32'h7FFF_FFFF, 0, CFG_ENTRIES, 0, 0, 0,
			RC_BELOW, 0},
		'{ROW_CMD, CMD_WRITE, 1, 31'h7FFF_FFFE, 32'h8000_0000, 0, CFG_ENTRIES, 0, 0, 0,
			RC_BELOW, 0},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd1, CFG_ENTRIES, 0, 1, 32'h7FFF_FFFF, RC_INTERP, 1},
		'{ROW_CMD, CMD_WRITE, 0, 31'd2147483000, 32'h8000_0000, 0, CFG_ENTRIES, 0, 0, 0,
			RC_BELOW, 0},
		'{ROW_CMD, CMD_WRITE, 1, 31'h7FFF_FFFF, 32'h7FFF_FFFF, 0, CFG_ENTRIES, 0, 0, 0,
			RC_BELOW, 0},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd1, CFG_ENTRIES, 0, 1, 32'h8000_0000, RC_INTERP, 1},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'h7FFF_FFFF, CFG_ENTRIES, 0, 1, 32'h7FFF_FFFF,
			RC_ABOVE, 1},
		// full table
		'{ROW_CFG, CMD_QUERY, 0, 0, 0, 0, CFG_ENTRIES, 7'd64, 0, 0, RC_BELOW, 0},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd63000, CFG_ENTRIES, 0, 1, 32'h003F_0000,
			RC_ABOVE, 63},
		'{ROW_CMD, CMD_QUERY, 0, 0, 0, 32'sd40500, CFG_ENTRIES, 0, 0, 0, RC_BELOW, 0}
	};

	// random phases: raw entry count, floor mode, sender idle percentage
	logic [CFG_DATA_W-1:0] ph_entries [NUM_PHASES] = '{7'd64, 7'd2, 7'd0, 7'd127,
		7'd9, 7'd1, 7'd65, 7'd17};
	logic                  ph_floor   [NUM_PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1,
		1'b1, 1'b0, 1'b0, 1'b1};
	int                    ph_idle    [NUM_PHASES] = '{0, 59, 9, 59, 0, 9, 59, 0};

	// stimulus
	initial begin
		lookup_answer_t ta;
		int n;
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = CMD_WRITE;
		entry_index    = '0;
		breakpoint     = '0;
		entry_value    = '0;
		query_point    = '0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_ENTRIES;
		cfg_data       = '0;
		typed_now      = 1'b0;
		no_answer      = '0;
		shadow_entries = 7'd2;
		shadow_floor   = 1'b1;
		idle_pct       = 0;
		errors         = 0;
		cycles         = 0;
		n_writes       = 0;
		n_queries      = 0;
		n_checked      = 0;
		n_reg_writes   = 0;
		code_seen      = '{0, 0, 0, 0};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// every entry gets written once so nothing unwritten is ever read
		for (int i = 0; i < DEPTH; i++)
			issue(CMD_WRITE, ENTRY_IDX_W'(i), BP_W'(1000 * i), VAL_W'(i << 16), $urandom,
				1'b0, no_answer);

		// directed table
		idle_pct = 9;
		foreach (dir_rows[r]) begin
			if (dir_rows[r].kind == ROW_CFG) begin
				set_reg(dir_rows[r].reg_idx, dir_rows[r].reg_data);
			end else begin
				ta.value = dir_rows[r].e_val;
				ta.code  = dir_rows[r].e_code;
				ta.seg   = dir_rows[r].e_seg;
				issue(dir_rows[r].op, dir_rows[r].idx, dir_rows[r].bp, dir_rows[r].val,
					dir_rows[r].qp, dir_rows[r].typed, ta);
			end
		end

		// random phases over several register settings
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_reg(CFG_ENTRIES, ph_entries[p]);
			set_reg(CFG_FLOOR, CFG_DATA_W'(ph_floor[p]));
			idle_pct = ph_idle[p];
			n = eff_entries(ph_entries[p][ENTRIES_W-1:0]);
			load_table(n);
			repeat (QUERIES_PER_PHASE) random_query(n - 1);
		end

		// wind down
		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_answers.size() != 0)
			report_mismatch("answers never seen", 0, pending_answers.size());
		$display("Ran %0d table writes and %0d queries (%0d answers checked), %0d register writes",
			n_writes, n_queries, n_checked, n_reg_writes);
		$display("Answers by kind: below %0d, interpolated %0d, above %0d, floored %0d",
			code_seen[RC_BELOW], code_seen[RC_INTERP], code_seen[RC_ABOVE], code_seen[RC_FLOOR]);
		if (errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

// ----- sim.f -----
src/plt_pkg.sv
src/plt_ram.sv
src/plt_div.sv
src/piecewise_linear_table_lookup.sv
tb/piecewise_linear_table_lookup_tb.sv
